// ===== hw/rtl/osm_pkg.sv =====
// Package for the order-statistic multiset: sizes, codes and item types.
package osm_pkg;

  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned IDX_W      = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned OUT_CNT_W  = 11;
  localparam int unsigned GROUP_SIZE = 32;
  localparam int unsigned NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_RANK = 2'd2
  } status_e;

  typedef struct packed {
    logic                    op;
    logic signed [VAL_W-1:0] operand;
  } osm_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [1:0]              status;
    logic [OUT_CNT_W-1:0]    count;
  } osm_out_t;

  // Broadcast to every cell in the cycle an item is accepted.
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [VAL_W-1:0] key;
    logic [IDX_W-1:0]        rem_idx;
    logic [CNT_W-1:0]        count;
  } osm_cmd_t;

endpackage

// ===== hw/rtl/osm_cell.sv =====
// One storage cell of the sorted chain: holds a single value.
module osm_cell (
  input  logic                            clk_i,
  input  logic [osm_pkg::IDX_W-1:0]       idx_i,
  input  osm_pkg::osm_cmd_t               cmd_i,
  input  logic signed [osm_pkg::VAL_W-1:0] prev_val_i,
  input  logic                            prev_gt_i,
  input  logic signed [osm_pkg::VAL_W-1:0] next_val_i,
  output logic signed [osm_pkg::VAL_W-1:0] val_o,
  output logic                            gt_o,
  output logic signed [osm_pkg::VAL_W-1:0] hit_val_o
);
  import osm_pkg::*;

  logic signed [VAL_W-1:0] val_q, val_d;
  logic                    occupied;

  assign occupied = CNT_W'(idx_i) < cmd_i.count;
  // Set at and after the insertion point; empty cells count as after.
  assign gt_o     = !(occupied && (val_q <= cmd_i.key));
  assign val_o    = val_q;

  always_comb begin
    val_d = val_q;
    if (cmd_i.ins && gt_o) begin
      val_d = prev_gt_i ? prev_val_i : cmd_i.key;
    end else if (cmd_i.rem && (idx_i >= cmd_i.rem_idx)) begin
      val_d = next_val_i;
    end
  end

  assign hit_val_o = (cmd_i.rem && (idx_i == cmd_i.rem_idx)) ? val_q : '0;

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== hw/rtl/osm_sel.sv =====
// Registered OR of one group of cell read-outs for the removed value.
module osm_sel (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [osm_pkg::VAL_W-1:0]       hit_i [osm_pkg::GROUP_SIZE],
  output logic [osm_pkg::VAL_W-1:0]       part_o
);
  import osm_pkg::*;

  logic [VAL_W-1:0] part_q, part_d;

  always_comb begin
    part_d = '0;
    for (int unsigned g = 0; g < GROUP_SIZE; g++) begin
      part_d = part_d | hit_i[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      part_q <= part_d;
    end
  end

  assign part_o = part_q;

endmodule

// ===== hw/rtl/order_statistic_multiset.sv =====
// Top level of the order-statistic multiset: cell chain, read-out and handshakes.
//
// Usage: send items on the input channel (in_valid_i / in_stall_o / in_data_i).
// op = insert stores operand beside its equals in sorted order; op = remove
// takes out the operand-th smallest value (rank counts from 1) and returns it.
// Each item yields exactly one result item on the output channel
// (out_valid_o / out_stall_i / out_data_o) with the removed value (zero for
// inserts and refused items), a status and the count after the item.
// The result passes through the read-out stage and then the output register.
// Throughput: one item per cycle while the input does not stall. All cells
// compare and shift in the cycle of acceptance; the removed value is gathered
// through a two-level registered OR tree (32-cell groups, then across groups).
// Reset empties the set (count zero) and drops any item in flight; stored
// values need no clearing. While the receiver stalls, the output register
// holds its result, one more item may enter the read-out stage, and then the
// input stalls until the output drains.
module order_statistic_multiset (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  osm_pkg::osm_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output osm_pkg::osm_out_t out_data_o
);
  import osm_pkg::*;

  localparam int unsigned PAD = NUM_GROUPS * GROUP_SIZE;

  logic              accept;
  logic              advance;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              s1_valid_q, s1_valid_d;
  status_e           s1_status_q, status_d;
  logic [CNT_W-1:0]  s1_count_q;
  logic              out_valid_q, out_valid_d;
  osm_out_t          out_data_q;
  osm_cmd_t          cmd;
  logic              rank_ok;
  logic              full;
  logic [VAL_W-1:0]  value_sum;

  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  logic                    cell_gt  [CAPACITY];
  logic [VAL_W-1:0]        hit_val  [PAD];
  logic [VAL_W-1:0]        part     [NUM_GROUPS];

  // Hold the input only while both read-out stages are full and stalled.
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);

  assign full    = count_q >= CNT_W'(CAPACITY);
  assign rank_ok = !in_data_i.operand[VAL_W-1] && (in_data_i.operand != '0) &&
                   (in_data_i.operand <= $signed({{(VAL_W-CNT_W){1'b0}}, count_q}));

  always_comb begin
    cmd         = '0;
    cmd.key     = in_data_i.operand;
    cmd.rem_idx = IDX_W'(in_data_i.operand - 1);
    cmd.count   = count_q;
    count_d     = count_q;
    status_d    = ST_OK;
    if (in_data_i.op == OP_INSERT) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        cmd.ins = accept;
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (!rank_ok) begin
        status_d = ST_RANK;
      end else begin
        cmd.rem = accept;
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] prev_val;
    logic                    prev_gt;
    logic signed [VAL_W-1:0] next_val;
    logic signed [VAL_W-1:0] hit;

    if (i == 0) begin : g_first
      assign prev_val = '0;
      assign prev_gt  = 1'b0;
    end else begin : g_mid
      assign prev_val = cell_val[i-1];
      assign prev_gt  = cell_gt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_val = '0;
    end else begin : g_inner
      assign next_val = cell_val[i+1];
    end

    osm_cell u_cell (
      .clk_i      (clk_i),
      .idx_i      (IDX_W'(i)),
      .cmd_i      (cmd),
      .prev_val_i (prev_val),
      .prev_gt_i  (prev_gt),
      .next_val_i (next_val),
      .val_o      (cell_val[i]),
      .gt_o       (cell_gt[i]),
      .hit_val_o  (hit)
    );
    assign hit_val[i] = hit;
  end

  for (genvar i = CAPACITY; i < PAD; i++) begin : g_pad
    assign hit_val[i] = '0;
  end

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    logic [VAL_W-1:0] grp_hit [GROUP_SIZE];
    for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_tap
      assign grp_hit[j] = hit_val[g*GROUP_SIZE + j];
    end
    osm_sel u_sel (
      .clk_i  (clk_i),
      .en_i   (accept),
      .hit_i  (grp_hit),
      .part_o (part[g])
    );
  end

  always_comb begin
    value_sum = '0;
    for (int unsigned g = 0; g < NUM_GROUPS; g++) begin
      value_sum = value_sum | part[g];
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= status_d;
      s1_count_q  <= count_d;
    end
    if (advance) begin
      out_data_q.value  <= $signed(value_sum);
      out_data_q.status <= s1_status_q;
      out_data_q.count  <= OUT_CNT_W'(s1_count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sim/order_statistic_multiset_test.sv =====
// Self-checking testbench for the order-statistic multiset: sorted-queue scoreboard, random traffic.
module order_statistic_multiset_test;
  import osm_pkg::*;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned REPORT_LIMIT = 10;

  // Keeps an ascending copy of the stored values and the results still owed.
  class osm_scoreboard;
    logic signed [VAL_W-1:0] sorted_copy[$];
    osm_out_t                pending_results[$];
    int unsigned             mismatches;

    function int unsigned stored();
      return sorted_copy.size();
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    function void note_item(osm_in_t item);
      osm_out_t res;
      int       pos;
      res = '0;
      res.status = ST_OK;
      if (item.op == OP_INSERT) begin
        if (sorted_copy.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // Place after any equals.
          pos = 0;
          while (pos < sorted_copy.size() && sorted_copy[pos] <= item.operand) pos++;
          sorted_copy.insert(pos, item.operand);
        end
      end else begin
        if (item.operand < 1 || item.operand > sorted_copy.size()) begin
          res.status = ST_RANK;
        end else begin
          res.value = sorted_copy[item.operand - 1];
          sorted_copy.delete(item.operand - 1);
        end
      end
      res.count = OUT_CNT_W'(sorted_copy.size());
      pending_results.push_back(res);
    endfunction

    function void check_result(osm_out_t got);
      osm_out_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: value %0d status %0d count %0d",
                   got.value, got.status, got.count);
        return;
      end
      want = pending_results.pop_front();
      if (got.value !== want.value || got.status !== want.status ||
          got.count !== want.count) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result mismatch: expected value %0d status %0d count %0d,",
                   want.value, want.status, want.count,
                   " got value %0d status %0d count %0d",
                   got.value, got.status, got.count);
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  osm_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  osm_out_t out_data;

  int unsigned   send_gap_pct  = 0;
  int unsigned   recv_hold_pct = 0;
  int unsigned   random_sent   = 0;
  int unsigned   quiet_cycles  = 0;
  osm_scoreboard sb;

  order_statistic_multiset dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_hold_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // End the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send(input op_e op, input logic signed [VAL_W-1:0] operand);
    osm_in_t item;
    item.op      = op;
    item.operand = operand;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sb.note_item(item);
    @(negedge clk);
  endtask

  // Hold the input off until every owed result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2:    return $signed($urandom_range(15)) - 8;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_rank(input int unsigned n);
    if (n != 0 && $urandom_range(9) != 0) begin
      case ($urandom_range(4))
        0:       return 1;
        1:       return n;
        default: return $urandom_range(n, 1);
      endcase
    end
    case ($urandom_range(3))
      0:       return 0;
      1:       return n + 1;
      2:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_item(input int unsigned ins_pct);
    if (random_sent == 400) begin
      wait_idle();
      send_gap_pct  = 56;
      recv_hold_pct = 8;
    end else if (random_sent == 800) begin
      wait_idle();
      send_gap_pct  = 0;
      recv_hold_pct = 0;
    end
    random_sent++;
    if ($urandom_range(99) < ins_pct) send(OP_INSERT, pick_value());
    else send(OP_REMOVE, pick_rank(sb.stored()));
  endtask

  initial begin
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty set, extremes, duplicates and every bad rank.
    send(OP_REMOVE, 1);
    send(OP_INSERT, 0);
    send(OP_INSERT, VAL_MAX);
    send(OP_INSERT, VAL_MIN);
    send(OP_INSERT, -1);
    send(OP_INSERT, 0);
    send(OP_INSERT, 1);
    send(OP_REMOVE, 0);
    send(OP_REMOVE, -1);
    send(OP_REMOVE, VAL_MIN);
    send(OP_REMOVE, VAL_MAX);
    send(OP_REMOVE, 7);
    send(OP_REMOVE, 6);
    send(OP_REMOVE, 1);
    send(OP_REMOVE, 2);
    send(OP_INSERT, 100);
    send(OP_INSERT, -100);
    send(OP_INSERT, 100);
    send(OP_REMOVE, 5);
    send(OP_REMOVE, 3);
    send(OP_REMOVE, 1);
    send(OP_REMOVE, 2);
    wait_idle();

    send_gap_pct  = 8;
    recv_hold_pct = 56;
    // Fill to capacity, churn at the full mark, then send mostly removals.
    while (sb.stored() < CAPACITY) random_item(97);
    repeat (40) random_item(50);
    repeat (60) random_item(20);

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== order_statistic_multiset.f =====
hw/rtl/osm_pkg.sv
hw/rtl/osm_cell.sv
hw/rtl/osm_sel.sv
hw/rtl/order_statistic_multiset.sv
sim/order_statistic_multiset_test.sv
